// File: sv/array_insert_delete_search_core_macros.svh
// ----------------------------------------------------------------------------
// array_insert_delete_search_core_macros
// assertion macros used by the array store sequencer rtl
// ----------------------------------------------------------------------------
`ifndef ARRAY_INSERT_DELETE_SEARCH_CORE_MACROS_SVH
`define ARRAY_INSERT_DELETE_SEARCH_CORE_MACROS_SVH

// same-cycle implication
`define AIDS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// next-cycle implication
`define AIDS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// File: sv/aids_pkg.sv
// ----------------------------------------------------------------------------
// aids_pkg
// shared widths, command and status codes, result type of the array store
// ----------------------------------------------------------------------------
package aids_pkg;

  localparam int unsigned DepthDefault = 64;
  localparam int unsigned CmdW  = 3;
  localparam int unsigned PosW  = 6;
  localparam int unsigned ValW  = 32;
  localparam int unsigned StatW = 2;
  localparam int unsigned LenW  = 7;

  typedef enum logic [CmdW-1:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_SEARCH = 3'd3,
    CMD_READ   = 3'd4
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NOTFOUND = 2'd1,
    STATUS_FULL     = 2'd2,
    STATUS_RANGE    = 2'd3
  } status_e;

  typedef struct packed {
    status_e                status;
    logic [PosW-1:0]        found_index;
    logic signed [ValW-1:0] read_value;
    logic [LenW-1:0]        length;
  } res_t;

endpackage

// File: sv/array_insert_delete_search_core.sv
// flow: an accepted item passes S_DISPATCH, then goes to S_DONE for append, errors and unused codes;
// read passes S_READ, insert S_SHIFT_UP and delete S_SHIFT_DN before S_DONE, shifting the entries
// behind the position; search passes S_SEARCH, comparing from index 0 and stopping at the first match
// the block takes one item at a time, bound by the single read and single write port of the store
// the next item is taken while a result waits in the output register
// reset: entry count cleared, store contents left as they are and never read before written
// ----------------------------------------------------------------------------
// array_insert_delete_search_core
// ordered store of signed words with append, insert, delete, search and read
// ----------------------------------------------------------------------------
module array_insert_delete_search_core #(
  parameter int unsigned DEPTH = aids_pkg::DepthDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [aids_pkg::CmdW-1:0]        cmd_i,
  input  logic [aids_pkg::PosW-1:0]        position_i,
  input  logic signed [aids_pkg::ValW-1:0] value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [aids_pkg::StatW-1:0]       status_o,
  output logic [aids_pkg::PosW-1:0]        found_index_o,
  output logic signed [aids_pkg::ValW-1:0] read_value_o,
  output logic [aids_pkg::LenW-1:0]        length_o
);
  import aids_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [ValW-1:0] mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic [ValW-1:0] mem_rdata;

  logic            res_valid;
  logic            res_ready;
  res_t            res;

  logic            out_valid_q;
  res_t            out_res_q;

  aids_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .pos_i      (position_i),
    .val_i      (value_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  aids_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // output register, frees the sequencer while a result waits
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_res_q.status;
  assign found_index_o = out_res_q.found_index;
  assign read_value_o  = out_res_q.read_value;
  assign length_o      = out_res_q.length;

endmodule

// File: sv/aids_mem.sv
// ----------------------------------------------------------------------------
// aids_mem
// entry store, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module aids_mem #(
  parameter int unsigned DEPTH = aids_pkg::DepthDefault,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [aids_pkg::ValW-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [aids_pkg::ValW-1:0] rdata_o
);
  import aids_pkg::*;

  logic [ValW-1:0] mem_q [DEPTH];
  logic [ValW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/aids_ctrl.sv
// ----------------------------------------------------------------------------
// aids_ctrl
// command sequencer: checks, shifts entries through the store, searches, reads
// ----------------------------------------------------------------------------
`include "array_insert_delete_search_core_macros.svh"

module aids_ctrl #(
  parameter int unsigned DEPTH = aids_pkg::DepthDefault,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [aids_pkg::CmdW-1:0] cmd_i,
  input  logic [aids_pkg::PosW-1:0] pos_i,
  input  logic [aids_pkg::ValW-1:0] val_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output aids_pkg::res_t            res_o,
  output logic                      mem_we_o,
  output logic [AW-1:0]             mem_waddr_o,
  output logic [aids_pkg::ValW-1:0] mem_wdata_o,
  output logic                      mem_re_o,
  output logic [AW-1:0]             mem_raddr_o,
  input  logic [aids_pkg::ValW-1:0] mem_rdata_i
);
  import aids_pkg::*;

  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned PCW = (CW > PosW) ? CW : PosW;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DISPATCH = 7'b0000010,
    S_SHIFT_UP = 7'b0000100,
    S_SHIFT_DN = 7'b0001000,
    S_SEARCH   = 7'b0010000,
    S_READ     = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic            pend_q, pend_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   wdst_q, wdst_d;
  cmd_e            cmd_q;
  logic [PosW-1:0] pos_q;
  logic [ValW-1:0] val_q;
  status_e         status_q, status_d;
  logic [PosW-1:0] found_q, found_d;
  logic [ValW-1:0] rdval_q, rdval_d;

  logic            in_accept;
  logic            full;
  logic [PCW-1:0]  pos_ext;
  logic [PCW-1:0]  cnt_ext;
  logic [PCW-1:0]  idx_ext;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign full       = (count_q == CW'(DEPTH));
  assign pos_ext    = PCW'(pos_q);
  assign cnt_ext    = PCW'(count_q);
  assign idx_ext    = PCW'(idx_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pend_d      = pend_q;
    idx_d       = idx_q;
    wdst_d      = wdst_q;
    status_d    = status_q;
    found_d     = found_q;
    rdval_d     = rdval_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = AW'(wdst_q);
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = AW'(idx_q);

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        status_d = STATUS_OK;
        found_d  = '0;
        rdval_d  = '0;
        pend_d   = 1'b0;
        state_d  = S_DONE;
        case (cmd_q)
          CMD_APPEND: begin
            if (full) begin
              status_d = STATUS_FULL;
            end else begin
              mem_we_o    = 1'b1;
              mem_waddr_o = AW'(count_q);
              mem_wdata_o = val_q;
              count_d     = count_q + CW'(1);
            end
          end
          CMD_INSERT: begin
            if (full) begin
              status_d = STATUS_FULL;
            end else if (pos_ext > cnt_ext) begin
              status_d = STATUS_RANGE;
            end else begin
              idx_d   = count_q;
              state_d = S_SHIFT_UP;
            end
          end
          CMD_DELETE: begin
            if (pos_ext >= cnt_ext) begin
              status_d = STATUS_RANGE;
            end else begin
              idx_d   = CW'(pos_ext + PCW'(1));
              state_d = S_SHIFT_DN;
            end
          end
          CMD_SEARCH: begin
            status_d = STATUS_NOTFOUND;
            idx_d    = '0;
            state_d  = S_SEARCH;
          end
          CMD_READ: begin
            if (pos_ext >= cnt_ext) begin
              status_d = STATUS_RANGE;
            end else begin
              mem_re_o    = 1'b1;
              mem_raddr_o = AW'(pos_q);
              state_d     = S_READ;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_SHIFT_UP: begin
        // move entry idx-1 to idx, walking down to the insert position
        if (pend_q) begin
          mem_we_o = 1'b1;
        end
        if (idx_ext > pos_ext) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = AW'(idx_q - CW'(1));
          pend_d      = 1'b1;
          wdst_d      = idx_q;
          idx_d       = idx_q - CW'(1);
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          mem_we_o    = 1'b1;
          mem_waddr_o = AW'(pos_q);
          mem_wdata_o = val_q;
          count_d     = count_q + CW'(1);
          state_d     = S_DONE;
        end
      end
      S_SHIFT_DN: begin
        // move entry idx to idx-1, walking up to the last entry
        if (pend_q) begin
          mem_we_o = 1'b1;
        end
        if (idx_q < count_q) begin
          mem_re_o = 1'b1;
          pend_d   = 1'b1;
          wdst_d   = idx_q - CW'(1);
          idx_d    = idx_q + CW'(1);
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          count_d = count_q - CW'(1);
          state_d = S_DONE;
        end
      end
      S_SEARCH: begin
        if (pend_q && (mem_rdata_i == val_q)) begin
          status_d = STATUS_OK;
          found_d  = PosW'(wdst_q);
          pend_d   = 1'b0;
          state_d  = S_DONE;
        end else if (idx_q < count_q) begin
          mem_re_o = 1'b1;
          pend_d   = 1'b1;
          wdst_d   = idx_q;
          idx_d    = idx_q + CW'(1);
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          state_d = S_DONE;
        end
      end
      S_READ: begin
        rdval_d = mem_rdata_i;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    wdst_q   <= wdst_d;
    status_q <= status_d;
    found_q  <= found_d;
    rdval_q  <= rdval_d;
    if (in_accept) begin
      cmd_q <= cmd_e'(cmd_i);
      pos_q <= pos_i;
      val_q <= val_i;
    end
  end

  assign res_valid_o       = (state_q == S_DONE);
  assign res_o.status      = status_q;
  assign res_o.found_index = found_q;
  assign res_o.read_value  = rdval_q;
  assign res_o.length      = LenW'(count_q);

  `AIDS_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CW'(DEPTH))
  `AIDS_ASSERT_IMP(a_idle_no_write, clk_i, rst_ni, state_q == S_IDLE, !mem_we_o)
  `AIDS_ASSERT_NXT(a_accept_dispatch, clk_i, rst_ni, in_accept, state_q == S_DISPATCH)
  `AIDS_ASSERT_NXT(a_done_release, clk_i, rst_ni, res_valid_o && res_ready_i, state_q == S_IDLE)
  `AIDS_ASSERT_NXT(a_count_step, clk_i, rst_ni, 1'b1, CW'(count_q - $past(count_q) + 1'b1) <= 2)

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the ordered word store: a scoreboard class keeps its
// own copy of the entries and the count, predicts the result of every accepted
// item and compares it field by field with what the block returns; directed
// corner items first, then random command mixes that fill, query and drain the
// store, under random idling on both sides
// ----------------------------------------------------------------------------
module tb_top;
  import aids_pkg::*;

  localparam int unsigned Depth         = DepthDefault;
  localparam int unsigned CmdCodes      = 1 << CmdW;
  localparam int unsigned PosMax        = (1 << PosW) - 1;
  localparam int unsigned RandItems     = 1300;
  localparam int unsigned WatchdogLimit = 2000;
  localparam logic signed [ValW-1:0] ValMax = {1'b0, {(ValW-1){1'b1}}};
  localparam logic signed [ValW-1:0] ValMin = {1'b1, {(ValW-1){1'b0}}};

  typedef enum logic [1:0] {MIX_EVEN, MIX_GROW, MIX_QUERY, MIX_SHRINK} mix_e;

  class store_scoreboard;
    logic signed [ValW-1:0] entries [Depth];
    int unsigned count = 0;
    res_t expected_q [$];
    int unsigned errors = 0;

    function void note_item(input logic [CmdW-1:0] cmd, input logic [PosW-1:0] pos,
                            input logic signed [ValW-1:0] val);
      res_t want;
      want = '0;
      want.status = STATUS_OK;
      case (cmd)
        CMD_APPEND: begin
          if (count >= Depth) begin
            want.status = STATUS_FULL;
          end else begin
            entries[count] = val;
            count++;
          end
        end
        CMD_INSERT: begin
          if (count >= Depth) begin
            want.status = STATUS_FULL;
          end else if (pos > count) begin
            want.status = STATUS_RANGE;
          end else begin
            for (int unsigned i = count; i > pos; i--) entries[i] = entries[i-1];
            entries[pos] = val;
            count++;
          end
        end
        CMD_DELETE: begin
          if (pos >= count) begin
            want.status = STATUS_RANGE;
          end else begin
            for (int unsigned i = pos; i + 1 < count; i++) entries[i] = entries[i+1];
            count--;
          end
        end
        CMD_SEARCH: begin
          want.status = STATUS_NOTFOUND;
          for (int unsigned i = 0; i < count; i++) begin
            if (entries[i] == val) begin
              want.status = STATUS_OK;
              want.found_index = PosW'(i);
              break;
            end
          end
        end
        CMD_READ: begin
          if (pos >= count) want.status = STATUS_RANGE;
          else want.read_value = entries[pos];
        end
        default: begin
        end
      endcase
      want.length = LenW'(count);
      expected_q.push_back(want);
    endfunction

    function void check_result(input res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result with no item pending, status %0d length %0d",
                 $time, got.status, got.length);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.found_index !== want.found_index) begin
        $display("%0t: found_index expected %0d actual %0d", $time, want.found_index,
                 got.found_index);
        errors++;
      end
      if (got.read_value !== want.read_value) begin
        $display("%0t: read_value expected %0d actual %0d", $time, want.read_value,
                 got.read_value);
        errors++;
      end
      if (got.length !== want.length) begin
        $display("%0t: length expected %0d actual %0d", $time, want.length, got.length);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic [CmdW-1:0]        cmd_i       = '0;
  logic [PosW-1:0]        position_i  = '0;
  logic signed [ValW-1:0] value_i     = '0;
  logic                   out_stall_i = 1'b0;
  logic                   in_stall_o;
  logic                   out_valid_o;
  logic [StatW-1:0]       status_o;
  logic [PosW-1:0]        found_index_o;
  logic signed [ValW-1:0] read_value_o;
  logic [LenW-1:0]        length_o;

  store_scoreboard sb = new();
  int unsigned idle_cycles = 0;

  array_insert_delete_search_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .found_index_o (found_index_o),
    .read_value_o  (read_value_o),
    .length_o      (length_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic signed [ValW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom;
    if (r < 7) return int'($urandom_range(0, 15)) - 8;
    if (r == 7) return ValMax;
    if (r == 8) return ValMin;
    if (sb.count != 0) return sb.entries[$urandom_range(0, sb.count - 1)];
    return $urandom;
  endfunction

  task automatic pick_item(input mix_e mix, output logic [CmdW-1:0] cmd,
                           output logic [PosW-1:0] pos, output logic signed [ValW-1:0] val);
    int unsigned r, wa, wi, wd, ws;
    case (mix)
      MIX_GROW: begin
        wa = 38; wi = 76; wd = 86; ws = 93;
      end
      MIX_SHRINK: begin
        wa = 10; wi = 20; wd = 80; ws = 90;
      end
      MIX_QUERY: begin
        wa = 15; wi = 30; wd = 40; ws = 70;
      end
      default: begin
        wa = 20; wi = 40; wd = 60; ws = 80;
      end
    endcase
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 32) == 0)
      cmd = CmdW'($urandom_range(int'(CMD_READ) + 1, CmdCodes - 1));
    else if (r < wa) cmd = CMD_APPEND;
    else if (r < wi) cmd = CMD_INSERT;
    else if (r < wd) cmd = CMD_DELETE;
    else if (r < ws) cmd = CMD_SEARCH;
    else cmd = CMD_READ;
    pos = PosW'($urandom);
    val = pick_value();
    case (cmd)
      CMD_INSERT: begin
        if ($urandom_range(0, 6) != 0)
          pos = PosW'($urandom_range(0, (sb.count > PosMax) ? PosMax : sb.count));
      end
      CMD_DELETE, CMD_READ: begin
        if (sb.count != 0 && $urandom_range(0, 6) != 0)
          pos = PosW'($urandom_range(0, sb.count - 1));
      end
      CMD_SEARCH: begin
        if (sb.count != 0 && $urandom_range(0, 4) < 3)
          val = sb.entries[$urandom_range(0, sb.count - 1)];
      end
      default: begin
      end
    endcase
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic push_item(input logic [CmdW-1:0] cmd, input logic [PosW-1:0] pos,
                           input logic signed [ValW-1:0] val, input int unsigned gap);
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    position_i <= pos;
    value_i    <= val;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      cmd_i      <= CmdW'($urandom);
      position_i <= PosW'($urandom);
      value_i    <= $urandom;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.expected_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin : result_stall
    int unsigned hold_len, run_len;
    forever begin
      hold_len = idle_len();
      if (hold_len != 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (hold_len - 1) @(negedge clk_i);
      end
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      repeat (run_len - 1) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin : monitor
    res_t got;
    bit moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_valid_i && in_stall_o === 1'b0) begin
        sb.note_item(cmd_i, position_i, value_i);
        moved = 1'b1;
      end
      if (out_valid_o === 1'b1 && !out_stall_i) begin
        got.status      = status_e'(status_o);
        got.found_index = found_index_o;
        got.read_value  = read_value_o;
        got.length      = length_o;
        sb.check_result(got);
        moved = 1'b1;
      end
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [CmdW-1:0]        cmd;
    logic [PosW-1:0]        pos;
    logic signed [ValW-1:0] val;
    int unsigned            done_items;
    bit                     calm;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty store: search, read, delete and insert past the end
    push_item(CMD_SEARCH, '0, '0, idle_len());
    push_item(CMD_READ, '0, '0, idle_len());
    push_item(CMD_DELETE, '0, '0, idle_len());
    push_item(CMD_INSERT, PosW'(1), 5, idle_len());
    push_item(CMD_APPEND, '0, ValMax, idle_len());
    push_item(CMD_APPEND, '1, ValMin, idle_len());
    push_item(CMD_INSERT, '0, -1, idle_len());
    // insert at the count acts as append
    push_item(CMD_INSERT, PosW'(3), 0, idle_len());
    push_item(CMD_INSERT, PosW'(PosMax), 1, idle_len());
    for (int p = 0; p < 4; p++) push_item(CMD_READ, PosW'(p), $urandom, idle_len());
    push_item(CMD_READ, PosW'(4), '0, idle_len());
    push_item(CMD_READ, PosW'(PosMax), '0, idle_len());
    push_item(CMD_SEARCH, PosW'($urandom), ValMin, idle_len());
    // duplicate key, first index wins
    push_item(CMD_APPEND, '0, -1, idle_len());
    push_item(CMD_SEARCH, '0, -1, idle_len());
    push_item(CMD_INSERT, PosW'(2), 42, idle_len());
    push_item(CMD_DELETE, PosW'(1), $urandom, idle_len());
    push_item(CMD_DELETE, PosW'(5), '0, idle_len());
    push_item(CMD_DELETE, PosW'(4), '0, idle_len());
    for (int c = int'(CMD_READ) + 1; c < CmdCodes; c++)
      push_item(CmdW'(c), PosW'($urandom), $urandom, idle_len());
    push_item(CMD_SEARCH, '0, 12345, idle_len());
    pause_until_drained();

    // fill to the top, then append and insert on a full store
    done_items = 0;
    while (sb.count < Depth) begin
      push_item(CMD_APPEND, PosW'($urandom), pick_value(), idle_len());
      done_items++;
    end
    repeat (3) push_item(CMD_APPEND, PosW'($urandom), pick_value(), idle_len());
    repeat (3) push_item(CMD_INSERT, PosW'($urandom), pick_value(), idle_len());
    push_item(CMD_INSERT, '0, pick_value(), idle_len());
    done_items += 7;

    for (int ph = 0; done_items < RandItems; ph++) begin
      calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 100; ) begin
        pick_item(mix_e'(ph % 4), cmd, pos, val);
        push_item(cmd, pos, val, calm ? 0 : idle_len());
        if (cmd <= CMD_READ) k++;
      end
      done_items += 100;
      if ($urandom_range(0, 2) == 0) pause_until_drained();
    end

    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (Depth + 10) @(negedge clk_i);
    if (sb.expected_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.expected_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/aids_pkg.sv
sv/aids_mem.sv
sv/aids_ctrl.sv
sv/array_insert_delete_search_core.sv
tb/tb_top.sv
